/* rtl/edr_pkg.sv */
// ----------------------------------------------------------------------------
// edr_pkg: shared types and constants of the dead-reckoning integrator
// CORDIC constants, arctan table, controller command and state types
// ----------------------------------------------------------------------------
package edr_pkg;

  localparam int unsigned CordicSteps = 16;
  localparam int unsigned StepW       = $clog2(CordicSteps + 1);
  localparam logic signed [33:0] CordicGain = 34'sh026DD3B6A;

  // sequencer phases
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CORDIC_INIT,
    ST_CORDIC_RUN,
    ST_CORDIC_DONE,
    ST_MAT,
    ST_ROW,
    ST_ACC,
    ST_OUT
  } state_e;

  // multiply-accumulate micro-op index within the matrix phase
  localparam int unsigned MatOps = 13;
  localparam int unsigned MatW   = 4;

  typedef struct packed {
    logic           load;      // capture input beat
    logic           c_init;    // start cordic for angle c_sel
    logic [1:0]     c_sel;
    logic           c_iter;    // one cordic iteration
    logic           c_store;   // store cos/sin of angle c_sel
    logic           mat_op;    // one matrix product micro-op
    logic [MatW-1:0] mat_idx;
    logic           row_op;    // one row velocity product
    logic [3:0]     row_idx;   // row*3 + column
    logic           acc_op;    // accumulate axis acc_idx
    logic [1:0]     acc_idx;
    logic           out_load;
  } cmd_t;

  function automatic logic signed [33:0] atan_lut(input logic [4:0] i);
    logic signed [33:0] r;
    case (i)
      5'd0:  r = 34'sh020000000; 5'd1:  r = 34'sh012E4051E;
      5'd2:  r = 34'sh009FB385B; 5'd3:  r = 34'sh0051111D4;
      5'd4:  r = 34'sh0028B0D43; 5'd5:  r = 34'sh00145D7E1;
      5'd6:  r = 34'sh000A2F61E; 5'd7:  r = 34'sh000517C55;
      5'd8:  r = 34'sh00028BE53; 5'd9:  r = 34'sh000145F2F;
      5'd10: r = 34'sh0000A2F98; 5'd11: r = 34'sh0000517CC;
      5'd12: r = 34'sh000028BE6; 5'd13: r = 34'sh0000145F3;
      5'd14: r = 34'sh00000A2FA; 5'd15: r = 34'sh00000517D;
      5'd16: r = 34'sh0000028BE; 5'd17: r = 34'sh00000145F;
      5'd18: r = 34'sh000000A30; 5'd19: r = 34'sh000000518;
      5'd20: r = 34'sh00000028C; 5'd21: r = 34'sh000000146;
      5'd22: r = 34'sh0000000A3; 5'd23: r = 34'sh000000051;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/edr_ctrl.sv */
// ----------------------------------------------------------------------------
// edr_ctrl: sequencer of the dead-reckoning integrator
// Steps three cordic runs, the matrix products, row sums and accumulation
// ----------------------------------------------------------------------------
module edr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic           out_busy_i,
  output edr_pkg::cmd_t  cmd_o
);
  import edr_pkg::*;

  state_e            state_q, state_d;
  logic [StepW-1:0]  cnt_q, cnt_d;
  logic [1:0]        ang_q, ang_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      ang_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ang_q   <= ang_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    ang_d   = ang_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_CORDIC_INIT;
          ang_d   = 2'd0;
        end
      end
      ST_CORDIC_INIT: begin
        state_d = ST_CORDIC_RUN;
        cnt_d   = '0;
      end
      ST_CORDIC_RUN: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(CordicSteps - 1)) state_d = ST_CORDIC_DONE;
      end
      ST_CORDIC_DONE: begin
        if (ang_q == 2'd2) begin
          state_d = ST_MAT;
          cnt_d   = '0;
        end else begin
          ang_d   = ang_q + 2'd1;
          state_d = ST_CORDIC_INIT;
        end
      end
      ST_MAT: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(MatOps - 1)) begin
          state_d = ST_ROW;
          cnt_d   = '0;
        end
      end
      ST_ROW: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(8)) begin
          state_d = ST_ACC;
          cnt_d   = '0;
        end
      end
      ST_ACC: begin
        cnt_d = cnt_q + StepW'(1);
        if (cnt_q == StepW'(2)) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (!out_busy_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_CORDIC_INIT: begin
        cmd_o.c_init = 1'b1;
        cmd_o.c_sel  = ang_q;
      end
      ST_CORDIC_RUN:  cmd_o.c_iter = 1'b1;
      ST_CORDIC_DONE: begin
        cmd_o.c_store = 1'b1;
        cmd_o.c_sel   = ang_q;
      end
      ST_MAT: begin
        cmd_o.mat_op  = 1'b1;
        cmd_o.mat_idx = cnt_q[MatW-1:0];
      end
      ST_ROW: begin
        cmd_o.row_op  = 1'b1;
        cmd_o.row_idx = cnt_q[3:0];
      end
      ST_ACC: begin
        cmd_o.acc_op  = 1'b1;
        cmd_o.acc_idx = cnt_q[1:0];
      end
      ST_OUT: cmd_o.out_load = !out_busy_i;
      default: ;
    endcase
  end

endmodule

/* rtl/edr_datapath.sv */
// ----------------------------------------------------------------------------
// edr_datapath: cordic, shared multiplier and position accumulators
// One cordic iteration or one matrix product per cycle (two for the first)
// ----------------------------------------------------------------------------
module edr_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  edr_pkg::cmd_t       cmd_i,
  input  logic [111:0]        in_data_i,
  output logic signed [31:0]  pos_x_o,
  output logic signed [31:0]  pos_y_o,
  output logic signed [31:0]  pos_z_o,
  output logic                sat_o
);
  import edr_pkg::*;

  // input capture
  logic signed [15:0] ang_q [3];
  logic signed [15:0] vel_q [3];
  logic        [15:0] dt_q;

  // cordic
  logic signed [33:0] cx_q, cy_q, cz_q;
  logic               neg_q;
  logic [4:0]         it_q;

  // trig results: cos/sin for roll, pitch, yaw (Q30, range +-1)
  logic signed [31:0] cs_q [3];
  logic signed [31:0] sn_q [3];

  // matrix entries and temporaries
  logic signed [31:0] r_q [9];
  logic signed [31:0] t1_q, t2_q;

  // row sums and accumulators
  logic signed [49:0] sum_q;
  logic signed [33:0] w_q [3];
  logic signed [47:0] acc_q [3];
  logic               sat_q;

  // ---------------- cordic ----------------
  logic signed [33:0] zin, zfold;
  logic               fold;
  always_comb begin
    zin   = 34'(ang_q[cmd_i.c_sel]) <<< 16;
    fold  = 1'b0;
    zfold = zin;
    if (zin > 34'sh040000000) begin
      zfold = zin - 34'sh080000000;
      fold  = 1'b1;
    end else if (zin < -34'sh040000000) begin
      zfold = zin + 34'sh080000000;
      fold  = 1'b1;
    end
  end

  logic signed [33:0] xs, ys, atv;
  assign xs  = cx_q >>> it_q;
  assign ys  = cy_q >>> it_q;
  assign atv = atan_lut(it_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ang_q[0] <= in_data_i[15:0];
      ang_q[1] <= in_data_i[31:16];
      ang_q[2] <= in_data_i[47:32];
      vel_q[0] <= in_data_i[63:48];
      vel_q[1] <= in_data_i[79:64];
      vel_q[2] <= in_data_i[95:80];
      dt_q     <= in_data_i[111:96];
    end
    if (cmd_i.c_init) begin
      cx_q  <= CordicGain;
      cy_q  <= '0;
      cz_q  <= zfold;
      neg_q <= fold;
      it_q  <= '0;
    end else if (cmd_i.c_iter) begin
      it_q <= it_q + 5'd1;
      if (!cz_q[33]) begin
        cx_q <= cx_q - ys;
        cy_q <= cy_q + xs;
        cz_q <= cz_q - atv;
      end else begin
        cx_q <= cx_q + ys;
        cy_q <= cy_q - xs;
        cz_q <= cz_q + atv;
      end
    end
    if (cmd_i.c_store) begin
      cs_q[cmd_i.c_sel] <= neg_q ? 32'(-cx_q) : 32'(cx_q);
      sn_q[cmd_i.c_sel] <= neg_q ? 32'(-cy_q) : 32'(cy_q);
    end
  end

  // ---------------- shared multiplier for matrix ----------------
  // roll=0, pitch=1, yaw=2
  logic signed [31:0] ma, mb;
  logic signed [63:0] mp;
  logic signed [31:0] mq;
  assign mp = ma * mb;
  assign mq = 32'(mp >>> 30);

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.mat_idx)
      4'd0:  begin ma = cs_q[2]; mb = cs_q[1]; end  // r00
      4'd1:  begin ma = cs_q[2]; mb = sn_q[1]; end  // t1 = cy*sp
      4'd2:  begin ma = t1_q;    mb = sn_q[0]; end  // t1*sr
      4'd3:  begin ma = sn_q[2]; mb = cs_q[0]; end  // sy*cr
      4'd4:  begin ma = t1_q;    mb = cs_q[0]; end  // t1*cr
      4'd5:  begin ma = sn_q[2]; mb = sn_q[0]; end  // sy*sr
      4'd6:  begin ma = sn_q[2]; mb = cs_q[1]; end  // r10
      4'd7:  begin ma = sn_q[2]; mb = sn_q[1]; end  // t2 = sy*sp
      4'd8:  begin ma = t2_q;    mb = sn_q[0]; end
      4'd9:  begin ma = cs_q[2]; mb = cs_q[0]; end  // cy*cr
      4'd10: begin ma = t2_q;    mb = cs_q[0]; end
      4'd11: begin ma = cs_q[2]; mb = sn_q[0]; end  // cy*sr
      4'd12: begin ma = cs_q[1]; mb = sn_q[0]; end  // r21
      default: ;
    endcase
  end

  // partial products held in r entries, combined after the product
  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_op) begin
      case (cmd_i.mat_idx)
        4'd0:  r_q[0] <= mq;
        4'd1:  t1_q   <= mq;
        4'd2:  r_q[1] <= mq;
        4'd3:  r_q[1] <= r_q[1] - mq;
        4'd4:  r_q[2] <= mq;
        4'd5:  r_q[2] <= r_q[2] + mq;
        4'd6:  r_q[3] <= mq;
        4'd7:  t2_q   <= mq;
        4'd8:  r_q[4] <= mq;
        4'd9:  r_q[4] <= r_q[4] + mq;
        4'd10: r_q[5] <= mq;
        4'd11: r_q[5] <= r_q[5] - mq;
        4'd12: begin
          r_q[7] <= mq;
          r_q[6] <= -sn_q[1];
        end
        default: ;
      endcase
    end
  end

  // r22 computed alongside r00 through a second product
  logic signed [63:0] p22;
  assign p22 = cs_q[1] * cs_q[0];
  always_ff @(posedge clk_i) begin
    if (cmd_i.mat_op && cmd_i.mat_idx == 4'd0) r_q[8] <= 32'(p22 >>> 30);
  end

  // ---------------- row sums: R[i][j]*v[j] ----------------
  logic [1:0]         rrow, rcol;
  logic signed [47:0] rp;
  always_comb begin
    case (cmd_i.row_idx)
      4'd0, 4'd1, 4'd2: rrow = 2'd0;
      4'd3, 4'd4, 4'd5: rrow = 2'd1;
      default:          rrow = 2'd2;
    endcase
    rcol = 2'(cmd_i.row_idx - {rrow, 1'b0} - 4'(rrow));
  end
  assign rp = r_q[cmd_i.row_idx] * vel_q[rcol];

  logic signed [49:0] sum_n;
  assign sum_n = (rcol == 2'd0) ? 50'(rp) : sum_q + 50'(rp);

  always_ff @(posedge clk_i) begin
    if (cmd_i.row_op) begin
      sum_q <= sum_n;
      if (rcol == 2'd2) w_q[rrow] <= 34'(sum_n >>> 16);
    end
  end

  // ---------------- accumulate ----------------
  logic signed [50:0] dp;
  logic signed [36:0] dlt;
  logic signed [48:0] nsum;
  assign dp   = w_q[cmd_i.acc_idx] * $signed({1'b0, dt_q});
  assign dlt  = 37'(dp >>> 14);
  assign nsum = 49'(acc_q[cmd_i.acc_idx]) + 49'(dlt);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q[0] <= '0;
      acc_q[1] <= '0;
      acc_q[2] <= '0;
      sat_q    <= 1'b0;
    end else if (cmd_i.acc_op) begin
      if (nsum[48] != nsum[47]) begin
        acc_q[cmd_i.acc_idx] <= nsum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        sat_q <= 1'b1;
      end else begin
        acc_q[cmd_i.acc_idx] <= nsum[47:0];
        // first axis of a sample starts the flag afresh
        if (cmd_i.acc_idx == 2'd0) sat_q <= 1'b0;
      end
    end
  end

  assign pos_x_o = acc_q[0][47:16];
  assign pos_y_o = acc_q[1][47:16];
  assign pos_z_o = acc_q[2][47:16];
  assign sat_o   = sat_q;

endmodule

/* rtl/euler_dead_reckoning_integrator_top.sv */
// ----------------------------------------------------------------------------
// euler_dead_reckoning_integrator_top: zyx euler dead-reckoning integrator
// ----------------------------------------------------------------------------
// One input beat carries roll, pitch, yaw, body velocity and delta time.
// The block rotates the velocity into the world frame with a zyx rotation
// built from cordic sines and cosines, scales it by delta time and adds it
// to a saturating 48-bit Q16 position per axis.
// Channels: s_axis carries the sample, m_axis the integer mm position and
// the saturation flag in tuser. One output beat per input beat.
// Each sample passes three cordic runs, the matrix products, the row products,
// the accumulation and the output step, in that order. The single cordic
// iterator and shared multiplier set the pace; one sample is worked at a time,
// so a new sample is taken only once the last result has gone into the output
// register.
// The result sits in an output register; a stalled receiver holds it, and
// the sequencer waits before it overwrites it.
// Reset clears the positions, the flag and the sequencer.
// ----------------------------------------------------------------------------
module euler_dead_reckoning_integrator_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // roll, pitch, yaw, vel_x, vel_y, vel_z, delta_time (16 bits each)
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x_mm, pos_y_mm, pos_z_mm (32 bits each)
  output logic [95:0]  m_axis_tdata,
  // saturated
  output logic         m_axis_tuser
);
  import edr_pkg::*;

  cmd_t               cmd;
  logic signed [31:0] px, py, pz;
  logic               sat;
  logic               ovalid_q;
  logic [95:0]        odata_q;
  logic               ouser_q;

  edr_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .out_busy_i (ovalid_q && !m_axis_tready),
    .cmd_o      (cmd)
  );

  edr_datapath u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i     (cmd),
    .in_data_i (s_axis_tdata),
    .pos_x_o   (px),
    .pos_y_o   (py),
    .pos_z_o   (pz),
    .sat_o     (sat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (cmd.out_load) begin
      ovalid_q <= 1'b1;
    end else if (m_axis_tready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.out_load) begin
      odata_q <= {pz, py, px};
      ouser_q <= sat;
    end
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tuser  = ouser_q;

endmodule

/* rtl/edr_checker.sv */
// ----------------------------------------------------------------------------
// edr_checker: port-level checks of the integrator
// ----------------------------------------------------------------------------
module edr_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid,
  input logic         s_axis_tready,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [95:0]  m_axis_tdata,
  input logic         m_axis_tuser
);
  // output beat held while stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable({m_axis_tuser, m_axis_tdata}))
    else $error("output beat changed under stall");

  // one sample at a time: no new accept right after one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("accepted two beats back to back");

  // a result does not rise just after an accepted sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid || $past(m_axis_tvalid))
    else $error("result appeared right after accept");

  // sequencer is back in idle when a fresh result appears
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("not ready with fresh result");
endmodule

bind euler_dead_reckoning_integrator_top edr_checker u_chk (
  .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready,
  .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
);

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench of the zyx euler dead-reckoning integrator
// Drives navigation samples through the input stream, predicts every world
// position with a cordic/matrix model of its own and compares each output beat.
// ----------------------------------------------------------------------------
module tb;
  import edr_pkg::*;

  typedef struct packed {
    logic [15:0] dt;
    logic signed [15:0] vz, vy, vx, yaw, pitch, roll;
  } sample_t;

  typedef struct packed {
    logic sat;
    logic [95:0] pos;
  } fix_t;

  localparam int unsigned LimitCycles = 1500000;
  localparam longint AccMax = 64'sh7FFF_FFFF_FFFF;
  localparam longint AccMin = -AccMax - 1;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;
  logic m_axis_tuser;

  sample_t samples_q[$];
  fix_t fixes_q[$];
  longint pos_acc[3];
  int errors = 0;
  int n_beats = 0;
  int n_sat = 0;
  int src_idle = 31, dst_idle = 55;
  int hold_cycles = 0;
  bit drain_pause = 0;
  longint unsigned cycles = 0;

  euler_dead_reckoning_integrator_top uut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint atan_entry(int i);
    longint t[16] = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
                      64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
                      64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
                      64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};
    return t[i];
  endfunction

  task automatic sin_cos(input logic signed [15:0] ang, output longint c, output longint s);
    longint z, x, y, nx;
    bit flip;
    z = longint'(ang) * 65536;
    x = 64'h26DD3B6A;
    y = 0;
    flip = 0;
    if (z > (64'sd1 <<< 30)) begin
      z -= 64'sd1 <<< 31; flip = 1;
    end else if (z < -(64'sd1 <<< 30)) begin
      z += 64'sd1 <<< 31; flip = 1;
    end
    for (int i = 0; i < CordicSteps; i++) begin
      if (z >= 0) begin
        nx = x - shr(y, i); y = y + shr(x, i); z -= atan_entry(i);
      end else begin
        nx = x + shr(y, i); y = y - shr(x, i); z += atan_entry(i);
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  task automatic predict_fix(input sample_t smp);
    longint cr, sr, cp, sp, cy, sy, d, n;
    longint rot[3][3];
    longint v[3];
    fix_t f;
    sin_cos(smp.roll, cr, sr);
    sin_cos(smp.pitch, cp, sp);
    sin_cos(smp.yaw, cy, sy);
    v[0] = smp.vx; v[1] = smp.vy; v[2] = smp.vz;
    rot[0][0] = qmul(cy, cp);
    rot[0][1] = qmul(qmul(cy, sp), sr) - qmul(sy, cr);
    rot[0][2] = qmul(qmul(cy, sp), cr) + qmul(sy, sr);
    rot[1][0] = qmul(sy, cp);
    rot[1][1] = qmul(qmul(sy, sp), sr) + qmul(cy, cr);
    rot[1][2] = qmul(qmul(sy, sp), cr) - qmul(cy, sr);
    rot[2][0] = -sp;
    rot[2][1] = qmul(cp, sr);
    rot[2][2] = qmul(cp, cr);
    f.sat = 0;
    for (int a = 0; a < 3; a++) begin
      d = rot[a][0] * v[0] + rot[a][1] * v[1] + rot[a][2] * v[2];
      d = ((d >>> 16) * longint'({48'd0, smp.dt})) >>> 14;
      n = pos_acc[a] + d;
      if (n > AccMax) begin
        n = AccMax; f.sat = 1;
      end else if (n < AccMin) begin
        n = AccMin; f.sat = 1;
      end
      pos_acc[a] = n;
      f.pos[a*32 +: 32] = n[47:16];
    end
    fixes_q.push_back(f);
  endtask

  function automatic sample_t rand_sample(bit fast);
    sample_t s;
    s = 112'({$urandom, $urandom, $urandom, $urandom});
    // drive toward the accumulator limits now and then
    if (fast) begin
      s.dt = 16'hFFFF;
      s.vx = $urandom_range(1) ? 16'sh7FFF : -16'sh8000;
      s.yaw = '0; s.pitch = '0; s.roll = '0;
    end
    return s;
  endfunction

  function automatic sample_t mk(int r, int p, int y, int vx, int vy, int vz, int dt);
    sample_t s;
    s.roll = 16'(r); s.pitch = 16'(p); s.yaw = 16'(y);
    s.vx = 16'(vx); s.vy = 16'(vy); s.vz = 16'(vz); s.dt = 16'(dt);
    return s;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_fix(sample_t'(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (samples_q.size() > 0 && !drain_pause &&
            $urandom_range(99) >= src_idle) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= samples_q.pop_front();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    fix_t exp_f;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        n_beats++;
        if (m_axis_tuser) n_sat++;
        if (fixes_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat, actual %h/%b", $time, m_axis_tdata, m_axis_tuser);
        end else begin
          exp_f = fixes_q.pop_front();
          for (int a = 0; a < 3; a++)
            if (m_axis_tdata[a*32 +: 32] !== exp_f.pos[a*32 +: 32]) begin
              errors++;
              $display("%0t: pos axis %0d expected %h actual %h", $time, a,
                       exp_f.pos[a*32 +: 32], m_axis_tdata[a*32 +: 32]);
            end
          if (m_axis_tuser !== exp_f.sat) begin
            errors++;
            $display("%0t: saturated expected %b actual %b", $time, exp_f.sat, m_axis_tuser);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic wait_empty();
    while (samples_q.size() > 0 || s_axis_tvalid || fixes_q.size() > 0)
      @(posedge clk_i);
  endtask

  initial begin
    pos_acc = '{0, 0, 0};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, quarter-turn folds, zero time
    samples_q.push_back(mk(0, 0, 0, 1000, 0, 0, 65535));
    samples_q.push_back(mk(-32768, 0, 0, 0, 1000, 0, 65535));
    samples_q.push_back(mk(0, -32768, 0, 1000, 0, 1000, 65535));
    samples_q.push_back(mk(0, 0, -32768, 1000, 1000, 0, 65535));
    samples_q.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 65535));
    samples_q.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768, 65535));
    samples_q.push_back(mk(16384, 16384, 16384, 500, -500, 500, 1000));
    samples_q.push_back(mk(16385, -16385, 16383, 500, -500, 500, 1000));
    samples_q.push_back(mk(-16384, -16384, -16384, -1, -1, -1, 65535));
    samples_q.push_back(mk(12345, -23456, 7777, 30000, -30000, 1234, 0));
    samples_q.push_back(mk(1, -1, 1, 1, -1, 1, 1));
    samples_q.push_back(mk(8192, 8192, 8192, 32767, 0, 0, 65535));
    samples_q.push_back(mk(-21845, 21845, -10923, 0, 32767, -32768, 40000));
    wait_empty();
    // long receiver hold-off with the sender still busy
    for (int i = 0; i < 20; i++) samples_q.push_back(rand_sample(0));
    hold_cycles = 2000;
    wait_empty();
    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 31 : (phase == 1) ? 55 : 0;
      dst_idle = (phase == 0) ? 55 : (phase == 1) ? 31 : 0;
      for (int i = 0; i < 520; i++) begin
        samples_q.push_back(rand_sample($urandom_range(99) < 3));
        if (i == 260) begin
          // sender pauses until all results are in
          while (samples_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
          drain_pause = 1;
          while (fixes_q.size() > 0) @(posedge clk_i);
          drain_pause = 0;
        end
      end
      wait_empty();
    end
    repeat (200) @(posedge clk_i);
    $display("tb: %0d output beats checked, %0d saturated", n_beats, n_sat);
    $display("tb: random angles, velocities and times under three idle mixes");
    if (errors == 0 && fixes_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
